// ===== rtl/plane_wave_field_eval_top_assert.svh =====
// Assertion macros shared by the plane wave evaluator RTL
`ifndef PLANE_WAVE_FIELD_EVAL_TOP_ASSERT_SVH
`define PLANE_WAVE_FIELD_EVAL_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset
`define PWFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("plane wave evaluator assertion failed");

// Check a property on every clock edge, reset included
`define PWFE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("plane wave evaluator assertion failed");

`endif

// ===== rtl/pwfe_pkg.sv =====
// Types, constants and helper functions for the plane wave evaluator
package pwfe_pkg;

  localparam int XW = 34;
  localparam int ZW = 34;
  localparam int GW = 34;
  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;

  typedef enum logic [2:0] {
    REG_DIR_X     = 3'd0,
    REG_DIR_Y     = 3'd1,
    REG_DIR_Z     = 3'd2,
    REG_WAVENUM   = 3'd3,
    REG_PH_OFFSET = 3'd4,
    REG_AMP_RE    = 3'd5,
    REG_AMP_IM    = 3'd6,
    REG_ADMIT     = 3'd7
  } reg_idx_t;

  // Side data that rides along with the rotation
  typedef struct packed {
    logic                 kind;
    logic [1:0]           quad;
    logic signed [GW-1:0] g;
  } tag_t;

  // Arctangent of 2^-i in Q0.32 turns
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -72'sh80000000) r = -32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Clamp to signed 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [71:0] v);
    logic signed [47:0] r;
    if (v > 72'sh7FFFFFFFFFFF) r = 48'sh7FFFFFFFFFFF;
    else if (v < -72'sh800000000000) r = -48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

// ===== rtl/pwfe_front.sv =====
// Phase, quadrant fold and normal-derivative gain for one field point
module pwfe_front import pwfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [31:0]   dir_x,
  input  logic signed [31:0]   dir_y,
  input  logic signed [31:0]   dir_z,
  input  logic [31:0]          wavenumber,
  input  logic [31:0]          phase_offset,
  input  logic                 in_v,
  output logic                 in_free,
  input  logic                 kind,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic signed [31:0]   norm_x,
  input  logic signed [31:0]   norm_y,
  input  logic signed [31:0]   norm_z,
  output logic                 out_v,
  input  logic                 out_free,
  output logic signed [ZW-1:0] z_out,
  output tag_t                 tag_out
);

  logic [4:0] v;
  logic [4:0] free;

  logic               k1, k2, k3, k4, k5;
  logic signed [63:0] pd0, pd1, pd2, pn0, pn1, pn2;
  logic signed [63:0] acc, dsum;
  logic [63:0]        lo_p;
  logic [29:0]        hi_p;
  logic signed [31:0] dn;
  logic [31:0]        phase;
  logic signed [GW-1:0] b;
  logic signed [ZW-1:0] z;
  logic [1:0]         q;
  logic signed [GW-1:0] g;

  logic [63:0]          lo_full, hi_full;
  logic signed [64:0]   bprod;
  logic signed [65:0]   gprod;
  logic [1:0]           q_next;
  logic [31:0]          zr;

  // Stage moves when empty or when its contents move on
  assign free[4] = !v[4] || out_free;
  assign free[3] = !v[3] || free[4];
  assign free[2] = !v[2] || free[3];
  assign free[1] = !v[1] || free[2];
  assign free[0] = !v[0] || free[1];
  assign in_free = free[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[0]) v[0] <= in_v;
      if (free[1]) v[1] <= v[0];
      if (free[2]) v[2] <= v[1];
      if (free[3]) v[3] <= v[2];
      if (free[4]) v[4] <= v[3];
    end
  end

  always_comb begin
    lo_full = acc[31:0] * wavenumber;
    hi_full = acc[63:32] * wavenumber;
    bprod   = $signed({1'b0, wavenumber}) * dn;
    gprod   = b * TWO_PI_Q28;
    q_next  = 2'((phase + 32'h2000_0000) >> 30);
    zr      = phase - {q_next, 30'd0};
  end

  // Direction products with point and normal
  always_ff @(posedge clk) begin
    if (free[0]) begin
      k1  <= kind;
      pd0 <= dir_x * pos_x;
      pd1 <= dir_y * pos_y;
      pd2 <= dir_z * pos_z;
      pn0 <= dir_x * norm_x;
      pn1 <= dir_y * norm_y;
      pn2 <= dir_z * norm_z;
    end
  end

  // Dot products
  always_ff @(posedge clk) begin
    if (free[1]) begin
      k2   <= k1;
      acc  <= pd0 + pd1 + pd2;
      dsum <= (pn0 >>> 2) + (pn1 >>> 2) + (pn2 >>> 2);
    end
  end

  // Scale by wavenumber, keep only the bits that reach the turn fraction
  always_ff @(posedge clk) begin
    if (free[2]) begin
      k3   <= k2;
      lo_p <= lo_full;
      hi_p <= hi_full[29:0];
      dn   <= sat32(72'(dsum >>> 28));
    end
  end

  // Fraction of a turn, and wavenumber times direction-normal dot
  always_ff @(posedge clk) begin
    if (free[3]) begin
      k4    <= k3;
      phase <= lo_p[61:30] + {hi_p, 2'b00} - phase_offset;
      b     <= GW'(bprod >>> 31);
    end
  end

  // Fold to the nearest quarter turn
  always_ff @(posedge clk) begin
    if (free[4]) begin
      k5 <= k4;
      q  <= q_next;
      z  <= ZW'($signed(zr));
      g  <= GW'(gprod >>> 31);
    end
  end

  assign out_v        = v[4];
  assign z_out        = z;
  assign tag_out.kind = k5;
  assign tag_out.quad = q;
  assign tag_out.g    = g;

endmodule

// ===== rtl/pwfe_cordic_cell.sv =====
// One CORDIC rotation cell with its own pipeline register
module pwfe_cordic_cell import pwfe_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_v,
  output logic                 in_free,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  tag_t                 tag_in,
  output logic                 out_v,
  input  logic                 out_free,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output tag_t                 tag_out
);

  localparam logic signed [ZW-1:0] ATAN = ZW'({2'b00, atan_turns(5'(SHIFT))});

  logic                 v;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  tag_t                 tag;
  logic signed [XW-1:0] xs, ys;

  assign in_free = !v || out_free;
  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_free) begin
      v <= in_v;
    end
  end

  // Rotate towards zero residual angle
  always_ff @(posedge clk) begin
    if (in_free) begin
      tag <= tag_in;
      if (!z_in[ZW-1]) begin
        x <= x_in - ys;
        y <= y_in + xs;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + ys;
        y <= y_in - xs;
        z <= z_in + ATAN;
      end
    end
  end

  assign out_v   = v;
  assign x_out   = x;
  assign y_out   = y;
  assign z_out   = z;
  assign tag_out = tag;

endmodule

// ===== rtl/pwfe_back.sv =====
// Pressure, velocity and normal derivative from the rotated unit vector
module pwfe_back import pwfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [31:0]   dir_x,
  input  logic signed [31:0]   dir_y,
  input  logic signed [31:0]   dir_z,
  input  logic signed [31:0]   amp_re,
  input  logic signed [31:0]   amp_im,
  input  logic [31:0]          admittance,
  input  logic                 in_v,
  output logic                 in_free,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  tag_t                 tag_in,
  output logic                 out_v,
  input  logic                 out_free,
  output logic signed [31:0]   press_re,
  output logic signed [31:0]   press_im,
  output logic signed [31:0]   vel_re [3],
  output logic signed [31:0]   vel_im [3],
  output logic signed [47:0]   grad_re,
  output logic signed [47:0]   grad_im
);

  logic [4:0] v;
  logic [4:0] free;

  logic signed [31:0]   dir [3];
  logic signed [XW-1:0] c, s;

  logic                 k1, k2, k3, k4, k5;
  logic signed [GW-1:0] g1, g2;
  logic signed [65:0]   m_rc, m_is, m_rs, m_ic;
  logic signed [31:0]   pr2, pi2, pr3, pi3, pr4, pi4;
  logic signed [63:0]   dr [3];
  logic signed [63:0]   di [3];
  logic signed [65:0]   gr, gi;
  logic signed [65:0]   vr [3];
  logic signed [65:0]   vi [3];
  logic signed [47:0]   gre4, gim4;

  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  assign free[4] = !v[4] || out_free;
  assign free[3] = !v[3] || free[4];
  assign free[2] = !v[2] || free[3];
  assign free[1] = !v[1] || free[2];
  assign free[0] = !v[0] || free[1];
  assign in_free = free[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[0]) v[0] <= in_v;
      if (free[1]) v[1] <= v[0];
      if (free[2]) v[2] <= v[1];
      if (free[3]) v[3] <= v[2];
      if (free[4]) v[4] <= v[3];
    end
  end

  // Apply the folded quarter turn exactly
  always_comb begin
    case (tag_in.quad)
      2'd1:    begin c = -y_in; s = x_in;  end
      2'd2:    begin c = -x_in; s = -y_in; end
      2'd3:    begin c = y_in;  s = -x_in; end
      default: begin c = x_in;  s = y_in;  end
    endcase
  end

  // Complex amplitude times rotation, partial products
  always_ff @(posedge clk) begin
    if (free[0]) begin
      k1   <= tag_in.kind;
      g1   <= tag_in.g;
      m_rc <= amp_re * c;
      m_is <= amp_im * s;
      m_rs <= amp_re * s;
      m_ic <= amp_im * c;
    end
  end

  // Pressure
  always_ff @(posedge clk) begin
    if (free[1]) begin
      k2  <= k1;
      g2  <= g1;
      pr2 <= sat32(72'((m_rc - m_is) >>> 30));
      pi2 <= sat32(72'((m_rs + m_ic) >>> 30));
    end
  end

  // Direction times pressure, gain times pressure
  always_ff @(posedge clk) begin
    if (free[2]) begin
      k3  <= k2;
      pr3 <= pr2;
      pi3 <= pi2;
      for (int i = 0; i < 3; i++) begin
        dr[i] <= dir[i] * pr2;
        di[i] <= dir[i] * pi2;
      end
      gr <= g2 * pi2;
      gi <= g2 * pr2;
    end
  end

  // Admittance scaling; derivative shift and clamp
  always_ff @(posedge clk) begin
    if (free[3]) begin
      k4  <= k3;
      pr4 <= pr3;
      pi4 <= pi3;
      for (int i = 0; i < 3; i++) begin
        vr[i] <= 33'(dr[i] >>> 31) * $signed({1'b0, admittance});
        vi[i] <= 33'(di[i] >>> 31) * $signed({1'b0, admittance});
      end
      gre4 <= k3 ? sat48((-(72'(gr))) >>> 12) : '0;
      gim4 <= k3 ? sat48(72'(gi) >>> 12) : '0;
    end
  end

  // Output register: velocity clamp, unused fields to zero
  always_ff @(posedge clk) begin
    if (free[4]) begin
      k5       <= k4;
      press_re <= pr4;
      press_im <= pi4;
      grad_re  <= gre4;
      grad_im  <= gim4;
      for (int i = 0; i < 3; i++) begin
        vel_re[i] <= k4 ? '0 : sat32(72'(vr[i] >>> 31));
        vel_im[i] <= k4 ? '0 : sat32(72'(vi[i] >>> 31));
      end
    end
  end

  assign out_v = v[4];

  `include "plane_wave_field_eval_top_assert.svh"

  // Kind 1 results never carry velocity
  `PWFE_ASSERT(a_kind_vel, (v[4] && k5) |-> (vel_re[0] == 0 && vel_im[2] == 0))

endmodule

// ===== rtl/plane_wave_field_eval_top.sv =====
// Top level of the acoustic plane wave field evaluator
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+--------------------------------------
//  in       | in_valid  | in_stall  | kind, pos_*, norm_*
//  out      | out_valid | out_stall | press_*, vel_*_*, grad_*
//  cfg      | cfg_we    | (none)    | cfg_index, cfg_data
//
// One point per cycle sustained while out_stall is low; the path runs through
// five front stages, one register per CORDIC cell and five back stages.
// Synchronous reset clears the stage valid flags and loads the register
// reset values. A stall on the output holds the result; stages behind it
// keep filling bubbles, so in_stall rises only once every stage is full.
module plane_wave_field_eval_top import pwfe_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] norm_x,
  input  logic signed [31:0] norm_y,
  input  logic signed [31:0] norm_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] press_re,
  output logic signed [31:0] press_im,
  output logic signed [31:0] vel_x_re,
  output logic signed [31:0] vel_x_im,
  output logic signed [31:0] vel_y_re,
  output logic signed [31:0] vel_y_im,
  output logic signed [31:0] vel_z_re,
  output logic signed [31:0] vel_z_im,
  output logic signed [47:0] grad_re,
  output logic signed [47:0] grad_im
);

  logic signed [31:0] dir_x, dir_y, dir_z, amp_re, amp_im;
  logic [31:0]        wavenumber, phase_offset, admittance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x        <= '0;
      dir_y        <= '0;
      dir_z        <= 32'sh4000_0000;
      wavenumber   <= '0;
      phase_offset <= '0;
      amp_re       <= '0;
      amp_im       <= '0;
      admittance   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DIR_X:     dir_x        <= cfg_data;
        REG_DIR_Y:     dir_y        <= cfg_data;
        REG_DIR_Z:     dir_z        <= cfg_data;
        REG_WAVENUM:   wavenumber   <= cfg_data;
        REG_PH_OFFSET: phase_offset <= cfg_data;
        REG_AMP_RE:    amp_re       <= cfg_data;
        REG_AMP_IM:    amp_im       <= cfg_data;
        REG_ADMIT:     admittance   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                 cv    [CORDIC_STAGES+1];
  logic                 cfree [CORDIC_STAGES+1];
  logic signed [XW-1:0] cx    [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy    [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz    [CORDIC_STAGES+1];
  tag_t                 ctag  [CORDIC_STAGES+1];
  logic                 front_free;
  logic signed [31:0]   vel_re [3];
  logic signed [31:0]   vel_im [3];

  assign in_stall = !front_free;
  assign cx[0] = CORDIC_X0;
  assign cy[0] = '0;

  pwfe_front u_front (
    .clk, .rst, .dir_x, .dir_y, .dir_z, .wavenumber, .phase_offset,
    .in_v(in_valid), .in_free(front_free), .kind,
    .pos_x, .pos_y, .pos_z, .norm_x, .norm_y, .norm_z,
    .out_v(cv[0]), .out_free(cfree[0]), .z_out(cz[0]), .tag_out(ctag[0])
  );

  // Row of rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    pwfe_cordic_cell #(.SHIFT(i)) u_cell (
      .clk, .rst,
      .in_v(cv[i]), .in_free(cfree[i]),
      .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .tag_in(ctag[i]),
      .out_v(cv[i+1]), .out_free(cfree[i+1]),
      .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1]), .tag_out(ctag[i+1])
    );
  end

  pwfe_back u_back (
    .clk, .rst, .dir_x, .dir_y, .dir_z, .amp_re, .amp_im, .admittance,
    .in_v(cv[CORDIC_STAGES]), .in_free(cfree[CORDIC_STAGES]),
    .x_in(cx[CORDIC_STAGES]), .y_in(cy[CORDIC_STAGES]), .tag_in(ctag[CORDIC_STAGES]),
    .out_v(out_valid), .out_free(!out_stall),
    .press_re, .press_im, .vel_re, .vel_im, .grad_re, .grad_im
  );

  assign vel_x_re = vel_re[0];
  assign vel_x_im = vel_im[0];
  assign vel_y_re = vel_re[1];
  assign vel_y_im = vel_im[1];
  assign vel_z_re = vel_re[2];
  assign vel_z_im = vel_im[2];

  `include "plane_wave_field_eval_top_assert.svh"

  // An empty output register means every stage can move
  `PWFE_ASSERT(a_no_stall_when_empty, !out_valid |-> !in_stall)
  // Velocity and derivative never appear in the same result
  `PWFE_ASSERT(a_exclusive_fields,
    (out_valid && (grad_re != 0 || grad_im != 0)) |->
    (vel_x_re == 0 && vel_y_im == 0 && vel_z_re == 0))
  // Reset leaves no result pending
  `PWFE_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid)

endmodule
